// ===== rtl/pwcg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcg_pkg
// Shared types, constants and helper functions of the plane-wave conjugate
// gradient coefficient update.
// ----------------------------------------------------------------------------
package pwcg_pkg;

  // Default width of the integer lattice indices
  localparam int PWCG_INDEX_WIDTH = 8;

  // Configuration register indexes
  localparam logic [2:0] REG_CELL_ROW_X      = 3'd0;
  localparam logic [2:0] REG_CELL_ROW_Y      = 3'd1;
  localparam logic [2:0] REG_CELL_ROW_Z      = 3'd2;
  localparam logic [2:0] REG_CUTOFF_ENERGY   = 3'd3;
  localparam logic [2:0] REG_DIRECTION_GAMMA = 3'd4;
  localparam logic [2:0] REG_TIME_STEP       = 3'd5;

  localparam int CFG_DATA_W = 60;
  localparam int CELL_W     = 20;

  // Register reset values
  localparam logic [59:0] CELL_ROW_X_RST = 60'h0000000_00010000;
  localparam logic [59:0] CELL_ROW_Y_RST = 60'h0000010_00000000;
  localparam logic [59:0] CELL_ROW_Z_RST = 60'h1000000_00000000;
  localparam logic [31:0] CUTOFF_RST    = 32'hFFFF_FFFF;
  localparam logic [30:0] GAMMA_RST     = 31'd0;
  localparam logic [31:0] TIME_STEP_RST = 32'h0001_0000;

  // 2*pi as unsigned Q.24, and one half in the same scale
  localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;
  localparam logic [63:0] HALF_Q24   = 64'h0000_0000_0080_0000;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } sat_t;

  // One lane of the restoring divider: partial remainder, dividend bits
  // still to come (quotient bits shift in from the bottom), overflow, sign
  typedef struct packed {
    logic [31:0] rem;
    logic [32:0] low;
    logic        ovf;
    logic        neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t          re;
    div_lane_t          im;
    logic [31:0]        mass;
    logic signed [31:0] dir_re;
    logic signed [31:0] dir_im;
    logic signed [31:0] wave_re;
    logic signed [31:0] wave_im;
    logic               in_cut;
    logic               sat;
    logic               last;
  } div_t;

  // Clamp a wide signed value to 32 bits
  function automatic sat_t sat_to32(input logic signed [63:0] x);
    sat_t r;
    if (x > 64'(S32_MAX)) begin
      r.val = S32_MAX;
      r.sat = 1'b1;
    end else if (x < 64'(S32_MIN)) begin
      r.val = S32_MIN;
      r.sat = 1'b1;
    end else begin
      r.val = x[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // Apply the signed step to the wavefunction, clamping both
  function automatic sat_t wave_update(input div_lane_t lane,
                                       input logic signed [31:0] w);
    sat_t               st;
    sat_t               r;
    logic signed [63:0] q;
    q = $signed(64'(lane.low));
    if (lane.ovf || lane.low > 33'h0_8000_0000) begin
      st.val = lane.neg ? S32_MIN : S32_MAX;
      st.sat = 1'b1;
    end else begin
      st = sat_to32(lane.neg ? -q : q);
    end
    r = sat_to32(64'(w) + 64'(st.val));
    r.sat = r.sat | st.sat;
    return r;
  endfunction

endpackage

// ===== rtl/pwcg_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcg_in_if
// Coefficient input channel: valid/ready handshake with one coefficient.
// ----------------------------------------------------------------------------
interface pwcg_in_if
  import pwcg_pkg::*;
#(
  parameter int INDEX_WIDTH = PWCG_INDEX_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [INDEX_WIDTH-1:0] index_x;
  logic signed [INDEX_WIDTH-1:0] index_y;
  logic signed [INDEX_WIDTH-1:0] index_z;
  logic signed [31:0]            force_re;
  logic signed [31:0]            force_im;
  logic signed [31:0]            dir_re;
  logic signed [31:0]            dir_im;
  logic signed [31:0]            wave_re;
  logic signed [31:0]            wave_im;
  logic [31:0]                   coef_mass;
  logic                          last_in;

  modport source (
    output valid, index_x, index_y, index_z, force_re, force_im, dir_re, dir_im,
           wave_re, wave_im, coef_mass, last_in,
    input  ready
  );
  modport sink (
    input  valid, index_x, index_y, index_z, force_re, force_im, dir_re, dir_im,
           wave_re, wave_im, coef_mass, last_in,
    output ready
  );
endinterface

// ===== rtl/pwcg_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcg_out_if
// Result channel: valid/ready handshake with one updated coefficient.
// ----------------------------------------------------------------------------
interface pwcg_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_dir_re;
  logic signed [31:0] new_dir_im;
  logic signed [31:0] new_wave_re;
  logic signed [31:0] new_wave_im;
  logic               within_cutoff;
  logic               saturated;
  logic               last_out;

  modport source (
    output valid, new_dir_re, new_dir_im, new_wave_re, new_wave_im,
           within_cutoff, saturated, last_out,
    input  ready
  );
  modport sink (
    input  valid, new_dir_re, new_dir_im, new_wave_re, new_wave_im,
           within_cutoff, saturated, last_out,
    output ready
  );
endinterface

// ===== rtl/pwcg_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcg_div_step
// One restoring division step: bring down a dividend bit, trial subtract
// the mass and shift the quotient bit in.
// ----------------------------------------------------------------------------
module pwcg_div_step
  import pwcg_pkg::*;
(
  input  div_lane_t   lane_in,
  input  logic [31:0] mass,
  output div_lane_t   lane_out
);

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  // Trial subtract of the mass from the partial remainder
  always_comb begin
    trial = {lane_in.rem, lane_in.low[32]};
    diff  = trial - {1'b0, mass};
    fits  = trial >= {1'b0, mass};
    lane_out.rem = fits ? diff[31:0] : trial[31:0];
    lane_out.low = {lane_in.low[31:0], fits};
    lane_out.ovf = lane_in.ovf;
    lane_out.neg = lane_in.neg;
  end

endmodule

// ===== rtl/plane_wave_cg_coefficient_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_wave_cg_coefficient_update
// Conjugate gradient direction and wavefunction update for one plane-wave
// coefficient per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   coef_in carries one coefficient per transaction (indices, force,
//   direction, wavefunction, mass); coef_out returns one updated coefficient
//   per transaction, in order. Registers are to be written by the user through
//   wr_en, wr_index and wr_data only while no transaction is in flight; the
//   block itself does not enforce this. Indexes of six and above are ignored.
//   The block takes one transaction per cycle while coef_out is not stalled:
//   6 stages form g squared, the cutoff test, the direction mix and the step
//   numerator, one stage sets up the divider, 33 restoring-division stages
//   (one quotient bit each, real and imaginary lanes side by side) divide by
//   the mass, and a last stage clamps and adds the step to the wavefunction.
//   Every stage holds its own valid bit. When coef_out stalls, the full
//   stages hold while empty stages further up keep filling, so input is
//   still taken until the pipe is full; nothing is lost or repeated.
//   Synchronous reset empties the pipeline and restores register defaults.
// ----------------------------------------------------------------------------
module plane_wave_cg_coefficient_update
  import pwcg_pkg::*;
#(
  parameter int INDEX_WIDTH = PWCG_INDEX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  pwcg_in_if.sink               coef_in,
  pwcg_out_if.source            coef_out,
  input  logic                  wr_en,
  input  logic [2:0]            wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  localparam int SW     = INDEX_WIDTH + 22;  // dot product width
  localparam int PW     = SW + 27;           // |s| * 2pi width
  localparam int GW     = PW - 24;           // g component width
  localparam int NDIV   = 33;
  localparam int NS     = 8 + NDIV;
  localparam int ST_OUT = NS - 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [59:0] cell_row_x, cell_row_y, cell_row_z;
  logic [31:0] cutoff_energy;
  logic [30:0] direction_gamma;
  logic [31:0] time_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_row_x      <= CELL_ROW_X_RST;
      cell_row_y      <= CELL_ROW_Y_RST;
      cell_row_z      <= CELL_ROW_Z_RST;
      cutoff_energy   <= CUTOFF_RST;
      direction_gamma <= GAMMA_RST;
      time_step       <= TIME_STEP_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_CELL_ROW_X:      cell_row_x      <= wr_data[59:0];
        REG_CELL_ROW_Y:      cell_row_y      <= wr_data[59:0];
        REG_CELL_ROW_Z:      cell_row_z      <= wr_data[59:0];
        REG_CUTOFF_ENERGY:   cutoff_energy   <= wr_data[31:0];
        REG_DIRECTION_GAMMA: direction_gamma <= wr_data[30:0];
        REG_TIME_STEP:       time_step       <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage valids and per-stage advance: a stage loads when it is empty or
  // the stage below it moves on
  // --------------------------------------------------------------------------
  logic [NS-1:0] v;
  logic [NS-1:0] en;
  logic [NS-1:0] v_next;

  always_comb begin
    en[NS-1] = !v[NS-1] || coef_out.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign v_next = {v[NS-2:0], coef_in.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) v[i] <= v_next[i];
      end
    end
  end

  assign coef_in.ready = en[0];

  // --------------------------------------------------------------------------
  // Stage 1: dot products of indices with cell rows, gamma * direction
  // --------------------------------------------------------------------------
  logic signed [INDEX_WIDTH-1:0] kx, ky, kz;
  logic signed [CELL_W-1:0]      xa, xb, xc, ya, yb, yc, za, zb, zc;
  logic signed [SW-1:0]          s_x_next, s_y_next, s_z_next;

  assign kx = coef_in.index_x;
  assign ky = coef_in.index_y;
  assign kz = coef_in.index_z;
  assign xa = cell_row_x[19:0];
  assign xb = cell_row_x[39:20];
  assign xc = cell_row_x[59:40];
  assign ya = cell_row_y[19:0];
  assign yb = cell_row_y[39:20];
  assign yc = cell_row_y[59:40];
  assign za = cell_row_z[19:0];
  assign zb = cell_row_z[39:20];
  assign zc = cell_row_z[59:40];

  always_comb begin
    s_x_next = SW'(kx) * SW'(xa) + SW'(ky) * SW'(xb) + SW'(kz) * SW'(xc);
    s_y_next = SW'(kx) * SW'(ya) + SW'(ky) * SW'(yb) + SW'(kz) * SW'(yc);
    s_z_next = SW'(kx) * SW'(za) + SW'(ky) * SW'(zb) + SW'(kz) * SW'(zc);
  end

  logic signed [SW-1:0] s1_sx, s1_sy, s1_sz;
  logic signed [63:0]   s1_p_re, s1_p_im;
  logic signed [31:0]   s1_f_re, s1_f_im, s1_d_re, s1_d_im, s1_w_re, s1_w_im;
  logic [31:0]          s1_mass;
  logic                 s1_last;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_sx   <= s_x_next;
      s1_sy   <= s_y_next;
      s1_sz   <= s_z_next;
      s1_p_re <= 64'(coef_in.dir_re) * $signed(64'(direction_gamma));
      s1_p_im <= 64'(coef_in.dir_im) * $signed(64'(direction_gamma));
      s1_f_re <= coef_in.force_re;
      s1_f_im <= coef_in.force_im;
      s1_d_re <= coef_in.dir_re;
      s1_d_im <= coef_in.dir_im;
      s1_w_re <= coef_in.wave_re;
      s1_w_im <= coef_in.wave_im;
      s1_mass <= coef_in.coef_mass;
      s1_last <= coef_in.last_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale by 2*pi with rounding; add the force to the rounded gamma * direction
  // --------------------------------------------------------------------------
  function automatic logic [GW-1:0] g_scale(input logic signed [SW-1:0] s);
    logic [SW-1:0] mag;
    logic [PW-1:0] prod;
    mag  = s[SW-1] ? SW'(-s) : SW'(s);
    prod = PW'(mag) * PW'(TWO_PI_Q24) + PW'(HALF_Q24);
    return prod[PW-1:24];
  endfunction

  function automatic sat_t mix(input logic signed [63:0] p,
                               input logic signed [31:0] f);
    logic [63:0]        mp;
    logic [63:0]        rnd;
    logic signed [63:0] r;
    mp  = p[63] ? 64'(-p) : 64'(p);
    rnd = (mp + HALF_Q24) >> 24;
    r   = p[63] ? -$signed(rnd) : $signed(rnd);
    return sat_to32(r + 64'(f));
  endfunction

  logic [GW-1:0]      s2_gx, s2_gy, s2_gz;
  sat_t               s2_m_re, s2_m_im;
  logic signed [31:0] s2_d_re, s2_d_im, s2_w_re, s2_w_im;
  logic [31:0]        s2_mass;
  logic               s2_last;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_gx   <= g_scale(s1_sx);
      s2_gy   <= g_scale(s1_sy);
      s2_gz   <= g_scale(s1_sz);
      s2_m_re <= mix(s1_p_re, s1_f_re);
      s2_m_im <= mix(s1_p_im, s1_f_im);
      s2_d_re <= s1_d_re;
      s2_d_im <= s1_d_im;
      s2_w_re <= s1_w_re;
      s2_w_im <= s1_w_im;
      s2_mass <= s1_mass;
      s2_last <= s1_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: square the g components, flag any at or above 256.0
  // --------------------------------------------------------------------------
  logic [47:0]        s3_qx, s3_qy, s3_qz;
  logic               s3_big;
  sat_t               s3_m_re, s3_m_im;
  logic signed [31:0] s3_d_re, s3_d_im, s3_w_re, s3_w_im;
  logic [31:0]        s3_mass;
  logic               s3_last;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_qx   <= 48'(s2_gx[23:0]) * 48'(s2_gx[23:0]);
      s3_qy   <= 48'(s2_gy[23:0]) * 48'(s2_gy[23:0]);
      s3_qz   <= 48'(s2_gz[23:0]) * 48'(s2_gz[23:0]);
      s3_big  <= (|s2_gx[GW-1:24]) || (|s2_gy[GW-1:24]) || (|s2_gz[GW-1:24]);
      s3_m_re <= s2_m_re;
      s3_m_im <= s2_m_im;
      s3_d_re <= s2_d_re;
      s3_d_im <= s2_d_im;
      s3_w_re <= s2_w_re;
      s3_w_im <= s2_w_im;
      s3_mass <= s2_mass;
      s3_last <= s2_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: cutoff test and direction select
  // --------------------------------------------------------------------------
  logic [49:0] g2_sum;
  logic        within_next;

  always_comb begin
    g2_sum      = 50'(s3_qx) + 50'(s3_qy) + 50'(s3_qz);
    within_next = !s3_big && (g2_sum[49:16] <= 34'(cutoff_energy));
  end

  logic signed [31:0] s4_d_re, s4_d_im, s4_w_re, s4_w_im;
  logic [31:0]        s4_mass;
  logic               s4_within, s4_sat, s4_last;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_d_re   <= within_next ? s3_m_re.val : s3_d_re;
      s4_d_im   <= within_next ? s3_m_im.val : s3_d_im;
      s4_sat    <= within_next && (s3_m_re.sat || s3_m_im.sat);
      s4_within <= within_next;
      s4_w_re   <= s3_w_re;
      s4_w_im   <= s3_w_im;
      s4_mass   <= s3_mass;
      s4_last   <= s3_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: |dir| * dt, zero mass taken as the smallest mass
  // --------------------------------------------------------------------------
  logic [31:0]        abs_re, abs_im;
  logic [63:0]        s5_pr_re, s5_pr_im;
  logic signed [31:0] s5_d_re, s5_d_im, s5_w_re, s5_w_im;
  logic [31:0]        s5_mass;
  logic               s5_within, s5_sat, s5_last;

  assign abs_re = s4_d_re[31] ? 32'(-s4_d_re) : 32'(s4_d_re);
  assign abs_im = s4_d_im[31] ? 32'(-s4_d_im) : 32'(s4_d_im);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_pr_re  <= 64'(abs_re) * 64'(time_step);
      s5_pr_im  <= 64'(abs_im) * 64'(time_step);
      s5_mass   <= (s4_mass == 32'd0) ? 32'd1 : s4_mass;
      s5_d_re   <= s4_d_re;
      s5_d_im   <= s4_d_im;
      s5_w_re   <= s4_w_re;
      s5_w_im   <= s4_w_im;
      s5_within <= s4_within;
      s5_sat    <= s4_sat;
      s5_last   <= s4_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: add half the mass for round to nearest
  // --------------------------------------------------------------------------
  logic [63:0]        s6_n_re, s6_n_im;
  logic signed [31:0] s6_d_re, s6_d_im, s6_w_re, s6_w_im;
  logic [31:0]        s6_mass;
  logic               s6_within, s6_sat, s6_last;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_n_re   <= s5_pr_re + 64'(s5_mass[31:1]);
      s6_n_im   <= s5_pr_im + 64'(s5_mass[31:1]);
      s6_mass   <= s5_mass;
      s6_d_re   <= s5_d_re;
      s6_d_im   <= s5_d_im;
      s6_w_re   <= s5_w_re;
      s6_w_im   <= s5_w_im;
      s6_within <= s5_within;
      s6_sat    <= s5_sat;
      s6_last   <= s5_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: divider set-up; a quotient of 2^33 or more is an overflow
  // --------------------------------------------------------------------------
  div_t div_init;
  div_t dv [NDIV+1];

  always_comb begin
    div_init.re.rem = {1'b0, s6_n_re[63:33]};
    div_init.re.low = s6_n_re[32:0];
    div_init.re.ovf = {1'b0, s6_n_re[63:33]} >= s6_mass;
    div_init.re.neg = s6_d_re[31];
    div_init.im.rem = {1'b0, s6_n_im[63:33]};
    div_init.im.low = s6_n_im[32:0];
    div_init.im.ovf = {1'b0, s6_n_im[63:33]} >= s6_mass;
    div_init.im.neg = s6_d_im[31];
    div_init.mass    = s6_mass;
    div_init.dir_re  = s6_d_re;
    div_init.dir_im  = s6_d_im;
    div_init.wave_re = s6_w_re;
    div_init.wave_im = s6_w_im;
    div_init.in_cut  = s6_within;
    div_init.sat     = s6_sat;
    div_init.last    = s6_last;
  end

  always_ff @(posedge clk) begin
    if (en[6]) dv[0] <= div_init;
  end

  // --------------------------------------------------------------------------
  // Stages 8 to 40: one quotient bit per stage in each lane
  // --------------------------------------------------------------------------
  for (genvar d = 0; d < NDIV; d++) begin : g_div
    div_t step_next;

    pwcg_div_step u_step_re (
      .lane_in  (dv[d].re),
      .mass     (dv[d].mass),
      .lane_out (step_next.re)
    );

    pwcg_div_step u_step_im (
      .lane_in  (dv[d].im),
      .mass     (dv[d].mass),
      .lane_out (step_next.im)
    );

    assign step_next.mass    = dv[d].mass;
    assign step_next.dir_re  = dv[d].dir_re;
    assign step_next.dir_im  = dv[d].dir_im;
    assign step_next.wave_re = dv[d].wave_re;
    assign step_next.wave_im = dv[d].wave_im;
    assign step_next.in_cut  = dv[d].in_cut;
    assign step_next.sat     = dv[d].sat;
    assign step_next.last    = dv[d].last;

    always_ff @(posedge clk) begin
      if (en[7+d]) dv[d+1] <= step_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: clamp the step, add to the wavefunction
  // --------------------------------------------------------------------------
  sat_t wave_re_next, wave_im_next;

  assign wave_re_next = wave_update(dv[NDIV].re, dv[NDIV].wave_re);
  assign wave_im_next = wave_update(dv[NDIV].im, dv[NDIV].wave_im);

  logic signed [31:0] out_d_re, out_d_im, out_w_re, out_w_im;
  logic               out_within, out_sat, out_last;

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_d_re   <= dv[NDIV].dir_re;
      out_d_im   <= dv[NDIV].dir_im;
      out_w_re   <= wave_re_next.val;
      out_w_im   <= wave_im_next.val;
      out_within <= dv[NDIV].in_cut;
      out_sat    <= dv[NDIV].sat || wave_re_next.sat || wave_im_next.sat;
      out_last   <= dv[NDIV].last;
    end
  end

  assign coef_out.valid         = v[ST_OUT];
  assign coef_out.new_dir_re    = out_d_re;
  assign coef_out.new_dir_im    = out_d_im;
  assign coef_out.new_wave_re   = out_w_re;
  assign coef_out.new_wave_im   = out_w_im;
  assign coef_out.within_cutoff = out_within;
  assign coef_out.saturated     = out_sat;
  assign coef_out.last_out      = out_last;

endmodule

// ===== sim/pwcg_coefficient_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwcg_coefficient_checker
// Watches the coefficient and result channels and the register write port.
// It predicts each updated coefficient from its own copy of the registers.
// It compares each result transaction, field by field, with the oldest
// prediction and counts the mismatches.
// ----------------------------------------------------------------------------
module pwcg_coefficient_checker
  import pwcg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  pwcg_in_if                    coef_in,
  pwcg_out_if                   coef_out,
  input  logic                  wr_en,
  input  logic [2:0]            wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output int                    errors,
  output int                    outstanding
);

  typedef struct {
    logic signed [31:0] dir_re;
    logic signed [31:0] dir_im;
    logic signed [31:0] wave_re;
    logic signed [31:0] wave_im;
    bit                 in_cut;
    bit                 sat;
    bit                 last;
  } coef_result_t;

  logic [59:0] row_x, row_y, row_z;
  logic [31:0] cutoff;
  logic [30:0] gamma;
  logic [31:0] dt;

  coef_result_t updates_q[$];

  // Magnitude of one reciprocal vector component in Q.16
  function automatic longint unsigned g_magnitude(input logic [59:0] row,
                                                  input logic signed [7:0] kx,
                                                  input logic signed [7:0] ky,
                                                  input logic signed [7:0] kz);
    longint s;
    longint unsigned m;
    s = longint'(kx) * longint'($signed(row[19:0]))
      + longint'(ky) * longint'($signed(row[39:20]))
      + longint'(kz) * longint'($signed(row[59:40]));
    m = (s < 0) ? longint'(-s) : longint'(s);
    return (m * longint'(TWO_PI_Q24) + 64'd8388608) >> 24;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint x, inout bit sat);
    if (x > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (x < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  // gamma * dir rounded on the magnitude, plus force
  function automatic logic signed [31:0] mix_direction(input logic signed [31:0] d,
                                                       input logic signed [31:0] f,
                                                       inout bit sat);
    longint p;
    longint unsigned m;
    p = longint'(d) * longint'({33'd0, gamma});
    m = ((p < 0) ? longint'(-p) : longint'(p));
    m = (m + 64'd8388608) >> 24;
    return clamp32(((p < 0) ? -longint'(m) : longint'(m)) + longint'(f), sat);
  endfunction

  // Wavefunction plus rounded dir * dt / mass
  function automatic logic signed [31:0] advance_wave(input logic signed [31:0] w,
                                                      input logic signed [31:0] d,
                                                      input logic [31:0] mass,
                                                      inout bit sat);
    longint unsigned mag, q;
    longint st;
    mag = (d < 0) ? longint'(-longint'(d)) : longint'(d);
    q = (mag * longint'({32'd0, dt}) + longint'({33'd0, mass[31:1]})) /
        longint'({32'd0, mass});
    if (q > 64'd2147483648) begin
      sat = 1'b1;
      st = (d < 0) ? -64'sd2147483648 : 64'sd2147483647;
    end else begin
      st = (d < 0) ? -longint'(q) : longint'(q);
      st = longint'(clamp32(st, sat));
    end
    return clamp32(longint'(w) + st, sat);
  endfunction

  function automatic coef_result_t predict_update();
    coef_result_t r;
    longint unsigned gx, gy, gz;
    logic [31:0] mass;
    bit sat;
    sat = 1'b0;
    gx = g_magnitude(row_x, coef_in.index_x, coef_in.index_y, coef_in.index_z);
    gy = g_magnitude(row_y, coef_in.index_x, coef_in.index_y, coef_in.index_z);
    gz = g_magnitude(row_z, coef_in.index_x, coef_in.index_y, coef_in.index_z);
    if (gx >= 64'd16777216 || gy >= 64'd16777216 || gz >= 64'd16777216)
      r.in_cut = 1'b0;
    else
      r.in_cut = ((gx * gx + gy * gy + gz * gz) >> 16) <= longint'({32'd0, cutoff});
    mass = (coef_in.coef_mass == 32'd0) ? 32'd1 : coef_in.coef_mass;
    r.dir_re = coef_in.dir_re;
    r.dir_im = coef_in.dir_im;
    if (r.in_cut) begin
      r.dir_re = mix_direction(coef_in.dir_re, coef_in.force_re, sat);
      r.dir_im = mix_direction(coef_in.dir_im, coef_in.force_im, sat);
    end
    r.wave_re = advance_wave(coef_in.wave_re, r.dir_re, mass, sat);
    r.wave_im = advance_wave(coef_in.wave_im, r.dir_im, mass, sat);
    r.sat = sat;
    r.last = coef_in.last_in;
    return r;
  endfunction

  // Track registers, predict on input transactions, compare on results
  always @(posedge clk) begin
    coef_result_t exp_r;
    if (rst) begin
      row_x <= CELL_ROW_X_RST;
      row_y <= CELL_ROW_Y_RST;
      row_z <= CELL_ROW_Z_RST;
      cutoff <= CUTOFF_RST;
      gamma <= GAMMA_RST;
      dt <= TIME_STEP_RST;
      updates_q.delete();
      errors <= 0;
      outstanding <= 0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_CELL_ROW_X:      row_x <= wr_data[59:0];
          REG_CELL_ROW_Y:      row_y <= wr_data[59:0];
          REG_CELL_ROW_Z:      row_z <= wr_data[59:0];
          REG_CUTOFF_ENERGY:   cutoff <= wr_data[31:0];
          REG_DIRECTION_GAMMA: gamma <= wr_data[30:0];
          REG_TIME_STEP:       dt <= wr_data[31:0];
          default: ;
        endcase
      end
      if (coef_out.valid && coef_out.ready) begin
        if (updates_q.size() == 0) begin
          $error("result transaction with no coefficient outstanding");
          errors <= errors + 1;
        end else begin
          exp_r = updates_q.pop_front();
          if (coef_out.new_dir_re !== exp_r.dir_re ||
              coef_out.new_dir_im !== exp_r.dir_im ||
              coef_out.new_wave_re !== exp_r.wave_re ||
              coef_out.new_wave_im !== exp_r.wave_im ||
              coef_out.within_cutoff !== exp_r.in_cut ||
              coef_out.saturated !== exp_r.sat ||
              coef_out.last_out !== exp_r.last)
            errors <= errors + 1;
          if (coef_out.new_dir_re !== exp_r.dir_re)
            $error("new_dir_re: expected %0d, got %0d", exp_r.dir_re, coef_out.new_dir_re);
          if (coef_out.new_dir_im !== exp_r.dir_im)
            $error("new_dir_im: expected %0d, got %0d", exp_r.dir_im, coef_out.new_dir_im);
          if (coef_out.new_wave_re !== exp_r.wave_re)
            $error("new_wave_re: expected %0d, got %0d", exp_r.wave_re,
                   coef_out.new_wave_re);
          if (coef_out.new_wave_im !== exp_r.wave_im)
            $error("new_wave_im: expected %0d, got %0d", exp_r.wave_im,
                   coef_out.new_wave_im);
          if (coef_out.within_cutoff !== exp_r.in_cut)
            $error("within_cutoff: expected %0b, got %0b", exp_r.in_cut,
                   coef_out.within_cutoff);
          if (coef_out.saturated !== exp_r.sat)
            $error("saturated: expected %0b, got %0b", exp_r.sat, coef_out.saturated);
          if (coef_out.last_out !== exp_r.last)
            $error("last_out: expected %0b, got %0b", exp_r.last, coef_out.last_out);
        end
      end
      if (coef_in.valid && coef_in.ready)
        updates_q.push_back(predict_update());
      outstanding <= updates_q.size();
    end
  end

endmodule

// ===== sim/plane_wave_cg_coefficient_update_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_wave_cg_coefficient_update_test
// Drives coefficient transactions and register settings into the update
// block under random source gaps and sink stalls, and reports the verdict
// from the failure count of the checker.
// ----------------------------------------------------------------------------
module plane_wave_cg_coefficient_update_test;
  import pwcg_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = REG_CELL_ROW_X;
  logic [CFG_DATA_W-1:0] wr_data = '0;
  int errors, outstanding;
  int gap_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  pwcg_in_if  coef_in();
  pwcg_out_if coef_out();

  plane_wave_cg_coefficient_update DUT (
    .clk(clk), .rst(rst), .coef_in(coef_in), .coef_out(coef_out),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  pwcg_coefficient_checker u_checker (
    .clk(clk), .rst(rst), .coef_in(coef_in), .coef_out(coef_out),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    coef_in.valid = 1'b0;
    coef_in.index_x = '0;
    coef_in.index_y = '0;
    coef_in.index_z = '0;
    coef_in.force_re = '0;
    coef_in.force_im = '0;
    coef_in.dir_re = '0;
    coef_in.dir_im = '0;
    coef_in.wave_re = '0;
    coef_in.wave_im = '0;
    coef_in.coef_mass = 32'd1;
    coef_in.last_in = 1'b0;
    coef_out.ready = 1'b0;
  end

  // Stall the result sink at random
  always @(posedge clk) begin
    coef_out.ready <= ($urandom_range(99) >= stall_pct);
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((coef_in.valid && coef_in.ready) || (coef_out.valid && coef_out.ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Present one register write and wait for the clock edge; the caller drops wr_en
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
  endtask

  // Send one coefficient, wait for its transaction, then maybe idle
  task automatic send_coef(input logic signed [7:0] ix, input logic signed [7:0] iy,
                           input logic signed [7:0] iz,
                           input logic signed [31:0] fre, input logic signed [31:0] fim,
                           input logic signed [31:0] dre, input logic signed [31:0] dim,
                           input logic signed [31:0] wre, input logic signed [31:0] wim,
                           input logic [31:0] mass, input logic last);
    coef_in.valid <= 1'b1;
    coef_in.index_x <= ix;
    coef_in.index_y <= iy;
    coef_in.index_z <= iz;
    coef_in.force_re <= fre;
    coef_in.force_im <= fim;
    coef_in.dir_re <= dre;
    coef_in.dir_im <= dim;
    coef_in.wave_re <= wre;
    coef_in.wave_im <= wim;
    coef_in.coef_mass <= mass;
    coef_in.last_in <= last;
    do @(posedge clk); while (!coef_in.ready);
    if ($urandom_range(99) < gap_pct) begin
      coef_in.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  // Hold the source until every outstanding result has arrived
  task automatic drain();
    coef_in.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Q8.24 value: full range, moderate, or near zero
  function automatic logic [31:0] rand_value();
    case ($urandom_range(2))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(32'h0400_0000))) - 32'sh0200_0000;
      default: return 32'($signed($urandom_range(32'h0010_0000))) - 32'sh0008_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(32'h0000_0100);
      default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
  endfunction

  function automatic logic [7:0] rand_index();
    if ($urandom_range(3) == 0) return 8'($urandom);
    return 8'($signed($urandom_range(8)) - 4);
  endfunction

  // One inverse-cell row of three signed entries, mostly small
  function automatic logic [59:0] rand_row();
    logic [59:0] r;
    for (int j = 0; j < 3; j++)
      r[20*j +: 20] = ($urandom_range(3) == 0) ? 20'($urandom) :
                      20'($signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000);
    return r;
  endfunction

  task automatic set_all(input logic [59:0] rx, input logic [59:0] ry,
                         input logic [59:0] rz, input logic [31:0] cut,
                         input logic [30:0] gam, input logic [31:0] step);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_CELL_ROW_X, rx);
    write_reg(REG_CELL_ROW_Y, ry);
    write_reg(REG_CELL_ROW_Z, rz);
    write_reg(REG_CUTOFF_ENERGY, {28'd0, cut});
    write_reg(REG_DIRECTION_GAMMA, {29'd0, gam});
    write_reg(REG_TIME_STEP, {28'd0, step});
    // unknown register indexes must be ignored
    write_reg(3'd6, 60'({$urandom, $urandom}));
    write_reg(3'd7, 60'({$urandom, $urandom}));
    wr_en <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset and extreme register settings, field extremes, large g, zero mass
    send_coef(0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, 32'h0001_0000, 1'b0);
    send_coef(127, -128, 127, 32'sh0100_0000, -32'sh0100_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'd0, 1'b1);
    send_coef(-128, 127, -128, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
              32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_coef(1, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0100_0000, -32'sh0100_0000,
              32'sh7FFF_0000, 32'sh8000_1000, 32'd1, 1'b1);
    send_coef(40, 40, 41, 32'sh0123_4567, -32'sh0765_4321, 32'sh0200_0000,
              32'sh0300_0000, 0, 0, 32'd0, 1'b0);
    set_all(60'h0000000_00010000, 60'h0000010_00000000, 60'h1000000_00000000,
            32'h0000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_coef(0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh8000_0000, 0, 0, 32'h0001_0000, 1'b1);
    send_coef(1, 1, 1, 32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0100, -32'sh0000_0100,
              0, 0, 32'hFFFF_FFFF, 1'b0);
    send_coef(0, 0, 0, 0, 0, 32'sh0000_0001, -32'sh0000_0001, 0, 0, 32'd3, 1'b0);
    send_coef(0, 0, 0, -32'sh0000_0001, 32'sh0000_0001, -32'sh0000_0001,
              32'sh0000_0001, 0, 0, 32'hFFFF_FFFF, 1'b1);
    set_all(60'hFFF_FFFF_FFFF_FFFF, 60'h8000080000_80000, 60'h7FFFF7FFFF7FFFF,
            32'hFFFF_FFFF, 31'h0100_0000, 32'd0);
    send_coef(1, 0, 0, 32'sh0000_1000, 32'sh0000_2000, 32'sh0000_3000, 32'sh0000_4000,
              32'sh7FFF_FFFF, 32'sh8000_0000, 32'd0, 1'b0);
    send_coef(-1, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh1000_0000,
              -32'sh1000_0000, 32'd1, 1'b1);
    send_coef(0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'd0, 1'b0);

    // Random phases, cycling the idling modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 49; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      case (ph)
        0: set_all(60'h0000000_00010000, 60'h0000010_00000000, 60'h1000000_00000000,
                   32'hFFFF_FFFF, 31'h0080_0000, 32'h0001_0000);
        3: set_all(60'd0, 60'd0, 60'd0, 32'd0, 31'd0, 32'd0);
        5: set_all(rand_row(), rand_row(), rand_row(), $urandom_range(32'h0100_0000),
                   31'h7FFF_FFFF, 32'hFFFF_FFFF);
        default: set_all(rand_row(), rand_row(), rand_row(), $urandom_range(32'h0400_0000),
                         31'($urandom_range(32'h0200_0000)),
                         $urandom_range(32'h0004_0000));
      endcase
      for (int n = 0; n < 216; n++) begin
        if (ph == 6 && n == 100) drain();
        send_coef(rand_index(), rand_index(), rand_index(), rand_value(), rand_value(),
                  rand_value(), rand_value(), rand_value(), rand_value(), rand_mass(),
                  1'($urandom_range(1)));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pwcg_pkg.sv
rtl/pwcg_in_if.sv
rtl/pwcg_out_if.sv
rtl/pwcg_div_step.sv
rtl/plane_wave_cg_coefficient_update.sv
sim/pwcg_coefficient_checker.sv
sim/plane_wave_cg_coefficient_update_test.sv
